// ===== design/ipcsum_pkg.sv =====
// Package for the IP family checksum engine.
// Holds the protocol mode codes, the checksum field positions and the
// one's-complement adder; it depends on nothing else.
`default_nettype none

package ipcsum_pkg;

    typedef enum logic [1:0] {
        MODE_IPV4 = 2'd0,
        MODE_ICMP = 2'd1,
        MODE_TCP  = 2'd2,
        MODE_UDP  = 2'd3
    } proto_mode_t;

    localparam int PSEUDO_HEADER_BYTES = 12;
    localparam int POS_WIDTH           = 6;
    localparam int POS_MAX             = 63;

    localparam logic [POS_WIDTH-1:0] POS_LIMIT = POS_WIDTH'(POS_MAX);

    // Register map: byte address of the protocol mode register.
    localparam logic [2:0] ADDR_PROTOCOL_MODE = 3'd0;

    // Checksum field offset counted from the first byte after any pseudo header.
    localparam logic [POS_WIDTH-1:0] CHECK_POS_IPV4 = POS_WIDTH'(10);
    localparam logic [POS_WIDTH-1:0] CHECK_POS_ICMP = POS_WIDTH'(2);
    localparam logic [POS_WIDTH-1:0] CHECK_POS_TCP  = POS_WIDTH'(16);
    localparam logic [POS_WIDTH-1:0] CHECK_POS_UDP  = POS_WIDTH'(6);

    // Absolute byte position of the first checksum byte within the packet.
    function automatic logic [POS_WIDTH-1:0] check_pos(input proto_mode_t mode);
        logic [POS_WIDTH-1:0] pos;
        begin
            case (mode)
                MODE_IPV4: pos = CHECK_POS_IPV4;
                MODE_ICMP: pos = CHECK_POS_ICMP;
                MODE_TCP:  pos = CHECK_POS_TCP + POS_WIDTH'(PSEUDO_HEADER_BYTES);
                MODE_UDP:  pos = CHECK_POS_UDP + POS_WIDTH'(PSEUDO_HEADER_BYTES);
                default:   pos = CHECK_POS_IPV4;
            endcase
            return pos;
        end
    endfunction

    // One's-complement add with the end-around carry folded back in.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            return s[15:0] + {15'd0, s[16]};
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/ip_family_checksum_engine.sv =====
// A checksum is registered in the output register, or in the skid entry while the output register waits.
// Throughput: one byte per cycle while the input is not stalled; the single one's-complement adder sets the pace.
// A two-entry result queue lets bytes keep flowing while a checksum waits to be taken;
// input stalls only while both entries are full.
// Reset clears the running sum, byte position, held byte, result queue and protocol mode.
`default_nettype none

module ip_family_checksum_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // byte input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  byte_value,
    input  wire logic        last_byte,
    // checksum output channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      checksum
);
    import ipcsum_pkg::*;

    proto_mode_t          mode_reg;
    logic [15:0]          sum_reg, sum_next;
    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic [7:0]           held_reg, held_next;
    logic                 odd_reg, odd_next;

    logic                 out_valid_reg, out_valid_next;
    logic [15:0]          out_sum_reg, out_sum_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [15:0]          skid_sum_reg, skid_sum_next;

    logic                 cfg_write;
    logic                 in_accept;
    logic                 skip;
    logic                 do_add;
    logic [15:0]          add_word;
    logic [15:0]          sum_added;
    logic                 push;
    logic                 pop;
    logic [15:0]          result;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == ADDR_PROTOCOL_MODE[2]) ? {30'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IPV4;
        end
        else if (cfg_write && (paddr[2] == ADDR_PROTOCOL_MODE[2]))
        begin
            mode_reg <= proto_mode_t'(pwdata[1:0]);
        end
    end

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    // Checksum datapath: at most one word is added per byte. A completed pair adds
    // the full word; a packet ending on an odd byte adds that byte with a zero pad.
    always_comb
    begin
        skip = (pos_reg == check_pos(mode_reg)) ||
               (pos_reg == check_pos(mode_reg) + POS_WIDTH'(1));

        do_add   = 1'b0;
        add_word = 16'd0;
        if (!skip)
        begin
            if (odd_reg)
            begin
                do_add   = 1'b1;
                add_word = {held_reg, byte_value};
            end
            else if (last_byte)
            begin
                do_add   = 1'b1;
                add_word = {byte_value, 8'd0};
            end
        end
        else if (odd_reg && last_byte)
        begin
            do_add   = 1'b1;
            add_word = {held_reg, 8'd0};
        end

        sum_added = do_add ? ones_add(sum_reg, add_word) : sum_reg;
        result    = ~sum_added;

        sum_next  = sum_reg;
        pos_next  = pos_reg;
        held_next = held_reg;
        odd_next  = odd_reg;
        if (in_accept)
        begin
            if (last_byte)
            begin
                sum_next  = 16'd0;
                pos_next  = '0;
                held_next = 8'd0;
                odd_next  = 1'b0;
            end
            else
            begin
                sum_next = sum_added;
                if (pos_reg != POS_LIMIT)
                begin
                    pos_next = pos_reg + POS_WIDTH'(1);
                end
                if (!skip)
                begin
                    held_next = odd_reg ? 8'd0 : byte_value;
                    odd_next  = !odd_reg;
                end
            end
        end
    end

    // Two-entry result queue: the output register and a skid entry behind it.
    assign push = in_accept && last_byte;
    assign pop  = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_sum_next    = out_sum_reg;
        skid_valid_next = skid_valid_reg;
        skid_sum_next   = skid_sum_reg;
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_sum_next    = skid_sum_reg;
                skid_valid_next = push;
                skid_sum_next   = result;
            end
            else
            begin
                out_valid_next = push;
                out_sum_next   = result;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_sum_next   = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg        <= 16'd0;
            pos_reg        <= '0;
            held_reg       <= 8'd0;
            odd_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg        <= sum_next;
            pos_reg        <= pos_next;
            held_reg       <= held_next;
            odd_reg        <= odd_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_sum_reg  <= out_sum_next;
        skid_sum_reg <= skid_sum_next;
    end

    assign out_valid = out_valid_reg;
    assign checksum  = out_sum_reg;

    // The skid entry only fills behind a waiting output transaction.
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register empty");

    // An accepted last byte always leaves a checksum pending in the output register on the next cycle.
    a_last_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_byte) |=> out_valid_reg)
        else $error("checksum missing after last byte");

    // Packet state starts fresh after a last byte.
    a_packet_clears : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last_byte) |=>
            (pos_reg == '0) && !odd_reg && (sum_reg == 16'd0))
        else $error("packet state not cleared after last byte");

endmodule

`default_nettype wire
